// ----- rtl/core/gbk_pkg.sv -----
// Shared types and constants for the grid bucket top-k keypoint selector.
// Field widths, register indexes and command codes; no dependencies.
`default_nettype none
package gbk_pkg;
   localparam int X_W       = 14;
   localparam int Y_W       = 13;
   localparam int SCORE_W   = 32;
   localparam int TAG_W     = 16;
   localparam int FRAC_W    = 4;
   localparam int BW_W      = 11;
   localparam int BH_W      = 10;
   localparam int MTP_W     = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;
   // Divider width covers image sizes up to 4096 plus a bucket size, and
   // bucket counts up to 64 x 64.
   localparam int DIV_W     = 13;

   typedef logic [CSR_IDX_W-1:0]  csr_idx_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   localparam csr_idx_type CSR_BKT_WIDTH  = 2'd0;
   localparam csr_idx_type CSR_BKT_HEIGHT = 2'd1;
   localparam csr_idx_type CSR_MAX_TOTAL  = 2'd2;

   localparam logic [BW_W-1:0]  BW_RESET  = 11'd128;
   localparam logic [BH_W-1:0]  BH_RESET  = 10'd128;
   localparam logic [MTP_W-1:0] MTP_RESET = 12'd512;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_FETCH  = 1'b1;
endpackage
`default_nettype wire

// ----- rtl/core/grid_bucket_topk_keypoint_select.sv -----
// Grid bucket top-k keypoint selector: bucketing, per-bucket top-k store, readout.
// Depends on gbk_pkg.
// Insert: a point that lands in a non-full bucket is appended; when the bucket is
//    full, a min search over its entries finds the weakest, replaced if weaker;
//    a point outside the image or beyond the frame budget is dropped.
// Fetch: the fill scan visits the buckets in turn, with a rank search over the
//    stored entries of an overflowing bucket (entry memory has one read port);
//    the result strobe rises in the same cycle that busy falls. No result stall.
// Reset: registers go to 128/128/512, the store empties, and busy stays high
//    while the grid size and bucket cap are derived.
`default_nettype none
module grid_bucket_topk_keypoint_select #(
   parameter int IMAGE_WIDTH      = 1024,
   parameter int IMAGE_HEIGHT     = 512,
   parameter int MAX_BUCKETS_X    = 16,
   parameter int MAX_BUCKETS_Y    = 8,
   parameter int MAX_PER_BUCKET   = 16,
   parameter int MAX_FRAME_POINTS = 65536
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic                       req_cmd,
   input  wire logic [gbk_pkg::X_W-1:0]    req_x_pos,
   input  wire logic [gbk_pkg::Y_W-1:0]    req_y_pos,
   input  wire logic [gbk_pkg::SCORE_W-1:0] req_score,
   input  wire logic [gbk_pkg::TAG_W-1:0]  req_tag,
   output logic                            rsp_valid,
   output logic [gbk_pkg::X_W-1:0]         rsp_out_x,
   output logic [gbk_pkg::Y_W-1:0]         rsp_out_y,
   output logic [gbk_pkg::SCORE_W-1:0]     rsp_out_score,
   output logic [gbk_pkg::TAG_W-1:0]       rsp_out_tag,
   output logic                            rsp_valid_res,
   output logic                            rsp_last,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire gbk_pkg::csr_idx_type       csr_index,
   input  wire gbk_pkg::csr_data_type      csr_wdata
);
   import gbk_pkg::*;

   localparam int NUM_BKT = MAX_BUCKETS_X * MAX_BUCKETS_Y;
   localparam int BKT_W   = (NUM_BKT > 1) ? $clog2(NUM_BKT) : 1;
   localparam int SLOT_W  = (MAX_PER_BUCKET > 1) ? $clog2(MAX_PER_BUCKET) : 1;
   localparam int SCNT_W  = $clog2(MAX_PER_BUCKET + 1);
   localparam int FILL_W  = $clog2(MAX_PER_BUCKET + 2);
   localparam int ARR_W   = (MAX_FRAME_POINTS > 1) ? $clog2(MAX_FRAME_POINTS) : 1;
   localparam int ARC_W   = $clog2(MAX_FRAME_POINTS + 1);
   localparam int KEY_W   = SCORE_W + ARR_W;
   localparam int ENT_W   = X_W + Y_W + TAG_W + KEY_W;
   localparam int ENT_D   = NUM_BKT * MAX_PER_BUCKET;
   localparam int ENT_AW  = (ENT_D > 1) ? $clog2(ENT_D) : 1;
   localparam int COL_W   = $clog2(MAX_BUCKETS_X + 1);
   localparam int ROW_W   = $clog2(MAX_BUCKETS_Y + 1);
   localparam int XI_W    = (MAX_BUCKETS_X > 1) ? $clog2(MAX_BUCKETS_X) : 1;
   localparam int YI_W    = (MAX_BUCKETS_Y > 1) ? $clog2(MAX_BUCKETS_Y) : 1;
   localparam int DCNT_W  = $clog2(DIV_W + 1);
   localparam int PX_W    = X_W - FRAC_W;
   localparam int PY_W    = Y_W - FRAC_W;

   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_CFG_GO   = 5'd1;
   localparam logic [4:0] S_CFG_COL  = 5'd2;
   localparam logic [4:0] S_CFG_ROW  = 5'd3;
   localparam logic [4:0] S_CFG_MUL  = 5'd4;
   localparam logic [4:0] S_CFG_NB   = 5'd5;
   localparam logic [4:0] S_CFG_CAP  = 5'd6;
   localparam logic [4:0] S_INS_X    = 5'd7;
   localparam logic [4:0] S_INS_Y    = 5'd8;
   localparam logic [4:0] S_INS_RD   = 5'd9;
   localparam logic [4:0] S_INS_FILL = 5'd10;
   localparam logic [4:0] S_INS_SCAN = 5'd11;
   localparam logic [4:0] S_INS_DEC  = 5'd12;
   localparam logic [4:0] S_SK_RD    = 5'd13;
   localparam logic [4:0] S_SK_CHK   = 5'd14;
   localparam logic [4:0] S_RK_I     = 5'd15;
   localparam logic [4:0] S_RK_K     = 5'd16;
   localparam logic [4:0] S_RK_J     = 5'd17;
   localparam logic [4:0] S_GET_RD   = 5'd18;
   localparam logic [4:0] S_GET_Q    = 5'd19;

   function automatic logic [ENT_AW-1:0] ent_addr(input logic [BKT_W-1:0] b,
                                                 input logic [SLOT_W-1:0] s);
      return ENT_AW'(b) * ENT_AW'(MAX_PER_BUCKET) + ENT_AW'(s);
   endfunction

   // Control and configuration
   logic [4:0]        state_ff, state_in;
   logic [BW_W-1:0]   bw_ff, bw_in;
   logic [BH_W-1:0]   bh_ff, bh_in;
   logic [MTP_W-1:0]  mtp_ff, mtp_in;
   logic [COL_W-1:0]  cols_ff, cols_in;
   logic [ROW_W-1:0]  rows_ff, rows_in;
   logic [DIV_W-1:0]  nb_ff, nb_in;
   logic [SCNT_W-1:0] cap_ff, cap_in;

   // Shared restoring divider, one quotient bit per cycle
   logic [DIV_W-1:0]  div_rem_ff, div_rem_in;
   logic [DIV_W-1:0]  div_quo_ff, div_quo_in;
   logic [DIV_W-1:0]  div_den_ff, div_den_in;
   logic [DCNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic              div_load;
   logic [DIV_W-1:0]  div_num, div_den;
   logic [DIV_W:0]    div_sh;
   logic              div_done;

   // Frame state
   logic [ARC_W-1:0]  arr_cnt_ff, arr_cnt_in;
   logic [BKT_W-1:0]  drain_b_ff, drain_b_in;
   logic [SCNT_W-1:0] drain_s_ff, drain_s_in;
   logic [NUM_BKT-1:0] fill_vld_ff, fill_vld_in;

   // Work registers
   logic [X_W-1:0]     ins_x_ff, ins_x_in;
   logic [Y_W-1:0]     ins_y_ff, ins_y_in;
   logic [TAG_W-1:0]   ins_tag_ff, ins_tag_in;
   logic [KEY_W-1:0]   ins_key_ff, ins_key_in;
   logic [DIV_W-1:0]   cx_ff, cx_in;
   logic [BKT_W-1:0]   b_ff, b_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [SCNT_W-1:0]  scan_iss_ff, scan_iss_in;
   logic [SLOT_W-1:0]  scan_tag_ff, scan_tag_in;
   logic               scan_vld_ff, scan_vld_in;
   logic [KEY_W-1:0]   min_key_ff, min_key_in;
   logic [SLOT_W-1:0]  min_slot_ff, min_slot_in;
   logic [BKT_W-1:0]   seek_b_ff, seek_b_in;
   logic [SCNT_W-1:0]  seek_s_ff, seek_s_in;
   logic               second_ff, second_in;
   logic [SCNT_W-1:0]  cur_s_ff, cur_s_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [SCNT_W-1:0]  rk_i_ff, rk_i_in;
   logic [KEY_W-1:0]   rk_key_ff, rk_key_in;
   logic [SCNT_W-1:0]  rk_cnt_ff, rk_cnt_in;
   logic [X_W-1:0]     res_x_ff, res_x_in;
   logic [Y_W-1:0]     res_y_ff, res_y_in;
   logic [SCORE_W-1:0] res_score_ff, res_score_in;
   logic [TAG_W-1:0]   res_tag_ff, res_tag_in;

   // Result registers
   logic               rsp_valid_ff, rsp_valid_in;
   logic [X_W-1:0]     rsp_x_ff, rsp_x_in;
   logic [Y_W-1:0]     rsp_y_ff, rsp_y_in;
   logic [SCORE_W-1:0] rsp_score_ff, rsp_score_in;
   logic [TAG_W-1:0]   rsp_tag_ff, rsp_tag_in;
   logic               rsp_vres_ff, rsp_vres_in;
   logic               rsp_last_ff, rsp_last_in;

   // Memories: per-bucket fill count and the entry store
   logic [FILL_W-1:0]  fill_mem [NUM_BKT];
   logic [FILL_W-1:0]  fill_q_ff;
   logic               fill_qv_ff;
   logic [BKT_W-1:0]   fill_raddr;
   logic               fill_we;
   logic [FILL_W-1:0]  fill_wdata;
   logic [ENT_W-1:0]   ent_mem [ENT_D];
   logic [ENT_W-1:0]   ent_q_ff;
   logic [ENT_AW-1:0]  ent_raddr, ent_waddr;
   logic               ent_we;

   // Derived values
   logic [BW_W-1:0]    bw_eff;
   logic [BH_W-1:0]    bh_eff;
   logic [FILL_W-1:0]  fill_eff;
   logic [FILL_W-1:0]  kept;
   logic [SCNT_W-1:0]  stored;
   logic [KEY_W-1:0]   ent_key;
   logic [PX_W-1:0]    req_px;
   logic [PY_W-1:0]    req_py, ins_py;
   logic               better;
   logic [SCNT_W-1:0]  rk_cnt_next;

   assign bw_eff   = (bw_ff == '0) ? BW_W'(1) : bw_ff;
   assign bh_eff   = (bh_ff == '0) ? BH_W'(1) : bh_ff;
   assign fill_eff = fill_qv_ff ? fill_q_ff : '0;
   assign kept     = (fill_eff < FILL_W'(cap_ff)) ? fill_eff : FILL_W'(cap_ff);
   assign stored   = (fill_ff > FILL_W'(MAX_PER_BUCKET)) ? SCNT_W'(MAX_PER_BUCKET)
                                                        : SCNT_W'(fill_ff);
   assign ent_key  = ent_q_ff[KEY_W-1:0];
   assign req_px   = req_x_pos[X_W-1:FRAC_W];
   assign req_py   = req_y_pos[Y_W-1:FRAC_W];
   assign ins_py   = ins_y_ff[Y_W-1:FRAC_W];
   assign better   = (ent_key > rk_key_ff) ||
                     ((ent_key == rk_key_ff) && (SCNT_W'(scan_tag_ff) < rk_i_ff));
   assign rk_cnt_next = rk_cnt_ff + SCNT_W'(better);

   assign div_sh   = {div_rem_ff, div_quo_ff[DIV_W-1]};
   assign div_done = (div_cnt_ff == '0);

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE) && !start;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_x     = rsp_x_ff;
   assign rsp_out_y     = rsp_y_ff;
   assign rsp_out_score = rsp_score_ff;
   assign rsp_out_tag   = rsp_tag_ff;
   assign rsp_valid_res = rsp_vres_ff;
   assign rsp_last      = rsp_last_ff;

   always_comb begin
      state_in     = state_ff;
      bw_in        = bw_ff;
      bh_in        = bh_ff;
      mtp_in       = mtp_ff;
      cols_in      = cols_ff;
      rows_in      = rows_ff;
      nb_in        = nb_ff;
      cap_in       = cap_ff;
      arr_cnt_in   = arr_cnt_ff;
      drain_b_in   = drain_b_ff;
      drain_s_in   = drain_s_ff;
      fill_vld_in  = fill_vld_ff;
      ins_x_in     = ins_x_ff;
      ins_y_in     = ins_y_ff;
      ins_tag_in   = ins_tag_ff;
      ins_key_in   = ins_key_ff;
      cx_in        = cx_ff;
      b_in         = b_ff;
      fill_in      = fill_ff;
      scan_iss_in  = scan_iss_ff;
      scan_tag_in  = scan_tag_ff;
      scan_vld_in  = 1'b0;
      min_key_in   = min_key_ff;
      min_slot_in  = min_slot_ff;
      seek_b_in    = seek_b_ff;
      seek_s_in    = seek_s_ff;
      second_in    = second_ff;
      cur_s_in     = cur_s_ff;
      slot_in      = slot_ff;
      rk_i_in      = rk_i_ff;
      rk_key_in    = rk_key_ff;
      rk_cnt_in    = rk_cnt_ff;
      res_x_in     = res_x_ff;
      res_y_in     = res_y_ff;
      res_score_in = res_score_ff;
      res_tag_in   = res_tag_ff;
      rsp_valid_in = 1'b0;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_score_in = rsp_score_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_vres_in  = rsp_vres_ff;
      rsp_last_in  = rsp_last_ff;
      div_load     = 1'b0;
      div_num      = '0;
      div_den      = DIV_W'(1);
      fill_raddr   = b_ff;
      fill_we      = 1'b0;
      fill_wdata   = '0;
      ent_raddr    = '0;
      ent_waddr    = ent_addr(b_ff, fill_ff[SLOT_W-1:0]);
      ent_we       = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_cmd == CMD_INSERT) begin
                  // Drop inserts past the frame budget without counting them.
                  if (arr_cnt_ff < ARC_W'(MAX_FRAME_POINTS)) begin
                     arr_cnt_in = arr_cnt_ff + ARC_W'(1);
                     ins_key_in = {req_score, ~arr_cnt_ff[ARR_W-1:0]};
                     ins_x_in   = req_x_pos;
                     ins_y_in   = req_y_pos;
                     ins_tag_in = req_tag;
                     if ((DIV_W'(req_px) < DIV_W'(IMAGE_WIDTH)) &&
                         (DIV_W'(req_py) < DIV_W'(IMAGE_HEIGHT))) begin
                        div_load = 1'b1;
                        div_num  = DIV_W'(req_px);
                        div_den  = DIV_W'(bw_eff);
                        state_in = S_INS_X;
                     end
                  end
               end else begin
                  seek_b_in = drain_b_ff;
                  seek_s_in = drain_s_ff;
                  second_in = 1'b0;
                  state_in  = S_SK_RD;
               end
            end else if (csr_valid) begin
               case (csr_index)
                  CSR_BKT_WIDTH:  bw_in  = csr_wdata[BW_W-1:0];
                  CSR_BKT_HEIGHT: bh_in  = csr_wdata[BH_W-1:0];
                  CSR_MAX_TOTAL:  mtp_in = csr_wdata[MTP_W-1:0];
                  default: ;
               endcase
               state_in = S_CFG_GO;
            end
         end

         // Grid size and bucket cap follow the registers.
         S_CFG_GO: begin
            div_load = 1'b1;
            div_num  = DIV_W'(IMAGE_WIDTH) + DIV_W'(bw_eff) - DIV_W'(1);
            div_den  = DIV_W'(bw_eff);
            state_in = S_CFG_COL;
         end
         S_CFG_COL: begin
            if (div_done) begin
               cols_in  = (div_quo_ff > DIV_W'(MAX_BUCKETS_X)) ? COL_W'(MAX_BUCKETS_X)
                                                              : COL_W'(div_quo_ff);
               div_load = 1'b1;
               div_num  = DIV_W'(IMAGE_HEIGHT) + DIV_W'(bh_eff) - DIV_W'(1);
               div_den  = DIV_W'(bh_eff);
               state_in = S_CFG_ROW;
            end
         end
         S_CFG_ROW: begin
            if (div_done) begin
               rows_in  = (div_quo_ff > DIV_W'(MAX_BUCKETS_Y)) ? ROW_W'(MAX_BUCKETS_Y)
                                                              : ROW_W'(div_quo_ff);
               state_in = S_CFG_MUL;
            end
         end
         S_CFG_MUL: begin
            nb_in    = DIV_W'(cols_ff) * DIV_W'(rows_ff);
            state_in = S_CFG_NB;
         end
         S_CFG_NB: begin
            div_load = 1'b1;
            div_num  = DIV_W'(mtp_ff);
            div_den  = (nb_ff == '0) ? DIV_W'(1) : nb_ff;
            state_in = S_CFG_CAP;
         end
         S_CFG_CAP: begin
            if (div_done) begin
               cap_in   = (div_quo_ff > DIV_W'(MAX_PER_BUCKET)) ? SCNT_W'(MAX_PER_BUCKET)
                                                               : SCNT_W'(div_quo_ff);
               state_in = S_IDLE;
            end
         end

         S_INS_X: begin
            if (div_done) begin
               cx_in    = div_quo_ff;
               div_load = 1'b1;
               div_num  = DIV_W'(ins_py);
               div_den  = DIV_W'(bh_eff);
               state_in = S_INS_Y;
            end
         end
         S_INS_Y: begin
            if (div_done) begin
               if ((cx_ff >= DIV_W'(cols_ff)) || (div_quo_ff >= DIV_W'(rows_ff))) begin
                  state_in = S_IDLE;
               end else begin
                  b_in = BKT_W'(cx_ff[XI_W-1:0]) * BKT_W'(MAX_BUCKETS_Y) +
                         BKT_W'(div_quo_ff[YI_W-1:0]);
                  state_in = S_INS_RD;
               end
            end
         end
         S_INS_RD: begin
            fill_raddr = b_ff;
            state_in   = S_INS_FILL;
         end
         S_INS_FILL: begin
            fill_in = fill_eff;
            if (fill_eff < FILL_W'(MAX_PER_BUCKET)) begin
               // Free slot: append in arrival order.
               ent_we      = 1'b1;
               ent_waddr   = ent_addr(b_ff, fill_eff[SLOT_W-1:0]);
               fill_we     = 1'b1;
               fill_wdata  = fill_eff + FILL_W'(1);
               fill_vld_in[b_ff] = 1'b1;
               state_in    = S_IDLE;
            end else begin
               scan_iss_in = '0;
               state_in    = S_INS_SCAN;
            end
         end
         S_INS_SCAN: begin
            // Stream the bucket's entries and keep the earliest weakest one.
            if (scan_iss_ff < SCNT_W'(MAX_PER_BUCKET)) begin
               ent_raddr   = ent_addr(b_ff, scan_iss_ff[SLOT_W-1:0]);
               scan_vld_in = 1'b1;
               scan_tag_in = scan_iss_ff[SLOT_W-1:0];
               scan_iss_in = scan_iss_ff + SCNT_W'(1);
            end
            if (scan_vld_ff) begin
               if ((scan_tag_ff == '0) || (ent_key < min_key_ff)) begin
                  min_key_in  = ent_key;
                  min_slot_in = scan_tag_ff;
               end
               if (scan_tag_ff == SLOT_W'(MAX_PER_BUCKET - 1)) begin
                  state_in = S_INS_DEC;
               end
            end
         end
         S_INS_DEC: begin
            if (ins_key_ff > min_key_ff) begin
               ent_we    = 1'b1;
               ent_waddr = ent_addr(b_ff, min_slot_ff);
            end
            fill_we    = 1'b1;
            fill_wdata = (fill_ff <= FILL_W'(MAX_PER_BUCKET)) ? fill_ff + FILL_W'(1)
                                                              : fill_ff;
            fill_vld_in[b_ff] = 1'b1;
            state_in   = S_IDLE;
         end

         S_SK_RD: begin
            fill_raddr = seek_b_ff;
            state_in   = S_SK_CHK;
         end
         S_SK_CHK: begin
            if (FILL_W'(seek_s_ff) < kept) begin
               if (!second_ff) begin
                  cur_s_in = seek_s_ff;
                  fill_in  = fill_eff;
                  b_in     = seek_b_ff;
                  if (fill_eff <= FILL_W'(cap_ff)) begin
                     slot_in  = seek_s_ff[SLOT_W-1:0];
                     state_in = S_GET_RD;
                  end else begin
                     rk_i_in  = '0;
                     state_in = S_RK_I;
                  end
               end else begin
                  // Another point follows: emit and hold the readout position.
                  rsp_valid_in = 1'b1;
                  rsp_vres_in  = 1'b1;
                  rsp_last_in  = 1'b0;
                  rsp_x_in     = res_x_ff;
                  rsp_y_in     = res_y_ff;
                  rsp_score_in = res_score_ff;
                  rsp_tag_in   = res_tag_ff;
                  drain_b_in   = seek_b_ff;
                  drain_s_in   = seek_s_ff;
                  state_in     = S_IDLE;
               end
            end else if (seek_b_ff == BKT_W'(NUM_BKT - 1)) begin
               // Nothing left: emit as last (or empty) and clear the frame.
               rsp_valid_in = 1'b1;
               rsp_vres_in  = second_ff;
               rsp_last_in  = 1'b1;
               rsp_x_in     = second_ff ? res_x_ff : '0;
               rsp_y_in     = second_ff ? res_y_ff : '0;
               rsp_score_in = second_ff ? res_score_ff : '0;
               rsp_tag_in   = second_ff ? res_tag_ff : '0;
               fill_vld_in  = '0;
               arr_cnt_in   = '0;
               drain_b_in   = '0;
               drain_s_in   = '0;
               state_in     = S_IDLE;
            end else begin
               seek_b_in = seek_b_ff + BKT_W'(1);
               seek_s_in = '0;
               state_in  = S_SK_RD;
            end
         end

         // Rank search: find the entry with exactly cur_s better entries.
         S_RK_I: begin
            ent_raddr = ent_addr(b_ff, rk_i_ff[SLOT_W-1:0]);
            state_in  = S_RK_K;
         end
         S_RK_K: begin
            rk_key_in   = ent_key;
            rk_cnt_in   = '0;
            scan_iss_in = '0;
            state_in    = S_RK_J;
         end
         S_RK_J: begin
            if (scan_iss_ff < stored) begin
               ent_raddr   = ent_addr(b_ff, scan_iss_ff[SLOT_W-1:0]);
               scan_vld_in = 1'b1;
               scan_tag_in = scan_iss_ff[SLOT_W-1:0];
               scan_iss_in = scan_iss_ff + SCNT_W'(1);
            end
            if (scan_vld_ff) begin
               rk_cnt_in = rk_cnt_next;
               if (SCNT_W'(scan_tag_ff) == stored - SCNT_W'(1)) begin
                  if (rk_cnt_next == cur_s_ff) begin
                     slot_in  = rk_i_ff[SLOT_W-1:0];
                     state_in = S_GET_RD;
                  end else if (rk_i_ff + SCNT_W'(1) == stored) begin
                     slot_in  = '0;
                     state_in = S_GET_RD;
                  end else begin
                     rk_i_in  = rk_i_ff + SCNT_W'(1);
                     state_in = S_RK_I;
                  end
               end
            end
         end

         S_GET_RD: begin
            ent_raddr = ent_addr(b_ff, slot_ff);
            state_in  = S_GET_Q;
         end
         S_GET_Q: begin
            res_x_in     = ent_q_ff[ENT_W-1 -: X_W];
            res_y_in     = ent_q_ff[ENT_W-X_W-1 -: Y_W];
            res_tag_in   = ent_q_ff[KEY_W+TAG_W-1 -: TAG_W];
            res_score_in = ent_q_ff[KEY_W-1 -: SCORE_W];
            // Look ahead for the next point to set the last marker.
            seek_b_in    = b_ff;
            seek_s_in    = cur_s_ff + SCNT_W'(1);
            second_in    = 1'b1;
            state_in     = S_SK_RD;
         end

         default: state_in = S_IDLE;
      endcase

      // Divider step
      if (div_load) begin
         div_rem_in = '0;
         div_quo_in = div_num;
         div_den_in = div_den;
         div_cnt_in = DCNT_W'(DIV_W);
      end else if (!div_done) begin
         if (div_sh >= {1'b0, div_den_ff}) begin
            div_rem_in = DIV_W'(div_sh - {1'b0, div_den_ff});
            div_quo_in = {div_quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            div_rem_in = div_sh[DIV_W-1:0];
            div_quo_in = {div_quo_ff[DIV_W-2:0], 1'b0};
         end
         div_den_in = div_den_ff;
         div_cnt_in = div_cnt_ff - DCNT_W'(1);
      end else begin
         div_rem_in = div_rem_ff;
         div_quo_in = div_quo_ff;
         div_den_in = div_den_ff;
         div_cnt_in = div_cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CFG_GO;
         bw_ff        <= BW_RESET;
         bh_ff        <= BH_RESET;
         mtp_ff       <= MTP_RESET;
         cols_ff      <= '0;
         rows_ff      <= '0;
         nb_ff        <= '0;
         cap_ff       <= '0;
         div_cnt_ff   <= '0;
         arr_cnt_ff   <= '0;
         drain_b_ff   <= '0;
         drain_s_ff   <= '0;
         fill_vld_ff  <= '0;
         scan_vld_ff  <= 1'b0;
         second_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bw_ff        <= bw_in;
         bh_ff        <= bh_in;
         mtp_ff       <= mtp_in;
         cols_ff      <= cols_in;
         rows_ff      <= rows_in;
         nb_ff        <= nb_in;
         cap_ff       <= cap_in;
         div_cnt_ff   <= div_cnt_in;
         arr_cnt_ff   <= arr_cnt_in;
         drain_b_ff   <= drain_b_in;
         drain_s_ff   <= drain_s_in;
         fill_vld_ff  <= fill_vld_in;
         scan_vld_ff  <= scan_vld_in;
         second_ff    <= second_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      div_rem_ff   <= div_rem_in;
      div_quo_ff   <= div_quo_in;
      div_den_ff   <= div_den_in;
      ins_x_ff     <= ins_x_in;
      ins_y_ff     <= ins_y_in;
      ins_tag_ff   <= ins_tag_in;
      ins_key_ff   <= ins_key_in;
      cx_ff        <= cx_in;
      b_ff         <= b_in;
      fill_ff      <= fill_in;
      scan_iss_ff  <= scan_iss_in;
      scan_tag_ff  <= scan_tag_in;
      min_key_ff   <= min_key_in;
      min_slot_ff  <= min_slot_in;
      seek_b_ff    <= seek_b_in;
      seek_s_ff    <= seek_s_in;
      cur_s_ff     <= cur_s_in;
      slot_ff      <= slot_in;
      rk_i_ff      <= rk_i_in;
      rk_key_ff    <= rk_key_in;
      rk_cnt_ff    <= rk_cnt_in;
      res_x_ff     <= res_x_in;
      res_y_ff     <= res_y_in;
      res_score_ff <= res_score_in;
      res_tag_ff   <= res_tag_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_score_ff <= rsp_score_in;
      rsp_tag_ff   <= rsp_tag_in;
      rsp_vres_ff  <= rsp_vres_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Fill count memory; a bucket whose valid bit is clear reads as empty.
   always_ff @(posedge clock) begin
      if (fill_we) begin
         fill_mem[b_ff] <= fill_wdata;
      end
      fill_q_ff  <= fill_mem[fill_raddr];
      fill_qv_ff <= fill_vld_ff[fill_raddr];
   end

   // Entry store: position, tag and rank key of each kept point.
   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_mem[ent_waddr] <= {ins_x_ff, ins_y_ff, ins_tag_ff, ins_key_ff};
      end
      ent_q_ff <= ent_mem[ent_raddr];
   end
endmodule
`default_nettype wire

// ----- rtl/core/gbk_check.sv -----
// Port-level checks for the keypoint selector, bound to its top level.
// Depends on gbk_pkg and grid_bucket_topk_keypoint_select.
`default_nettype none
module gbk_check (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        start,
   input wire logic                        busy,
   input wire logic                        req_cmd,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_valid_res,
   input wire logic                        rsp_last,
   input wire logic [gbk_pkg::SCORE_W-1:0] rsp_out_score
);
   import gbk_pkg::*;

   // A result only follows a cycle of work.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("result without preceding work");

   // Drop nothing into back-to-back strobes: one fetch, one result.
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe held two cycles");

   // An empty answer closes the frame.
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_valid_res) |-> (rsp_last && (rsp_out_score == '0)))
      else $error("empty result not marked last or not zero");

   // An insert produces no result.
   a_insert_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_cmd == CMD_INSERT)) |=> !rsp_valid)
      else $error("result after insert");
endmodule

bind grid_bucket_topk_keypoint_select gbk_check u_gbk_check (.*);
`default_nettype wire
